FILE: src/qpe_pkg.sv
`timescale 1ns / 1ps

package qpe_pkg;

   localparam int unsigned RUN_MAX = 9;
   localparam int unsigned RUN_COUNT_WIDTH = 4;
   localparam int unsigned BREAK_COLUMN_WIDTH = 7;
   localparam int unsigned COLUMN_WIDTH = 8;

   localparam logic CMD_ENCODE = 1'b0;
   localparam logic CMD_END = 1'b1;

   localparam logic [7:0] CHAR_EQUALS = 8'h3D;
   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB = 8'h09;
   localparam logic [7:0] CHAR_DASH = 8'h2D;
   localparam logic [7:0] PRINTABLE_LOW = 8'd32;
   localparam logic [7:0] PRINTABLE_HIGH = 8'd126;
   localparam logic [7:0] ESCAPE_COLUMNS = 8'd3;

   localparam logic [BREAK_COLUMN_WIDTH-1:0] ESCAPE_BREAK_RESET = 7'd72;
   localparam logic [BREAK_COLUMN_WIDTH-1:0] LITERAL_BREAK_RESET = 7'd75;

   typedef enum logic {
      CSR_ESCAPE_BREAK_COLUMN = 1'b0,
      CSR_LITERAL_BREAK_COLUMN = 1'b1
   } csr_index_type;

   typedef logic [7:0] char_type;

   typedef struct packed {
      logic [COLUMN_WIDTH-1:0] column;
      logic after_space;
   } line_state_type;

   typedef struct packed {
      char_type [RUN_MAX-1:0] chars;
      logic [RUN_COUNT_WIDTH-1:0] count;
   } run_type;

   function automatic char_type hex_digit(input logic [3:0] nibble);
      char_type digit;
      if (nibble < 4'd10) begin
         digit = 8'h30 + {4'd0, nibble};
      end else begin
         digit = 8'h37 + {4'd0, nibble};
      end
      return digit;
   endfunction

endpackage

FILE: src/qpe_req_if.sv
`timescale 1ns / 1ps

interface qpe_req_if;
   logic valid;
   logic ready;
   logic command;
   logic [7:0] in_byte;

   modport source (output valid, output command, output in_byte, input ready);
   modport sink (input valid, input command, input in_byte, output ready);
endinterface

FILE: src/qpe_rsp_if.sv
`timescale 1ns / 1ps

interface qpe_rsp_if;
   logic valid;
   logic ready;
   logic [7:0] out_char;
   logic last_of_run;

   modport source (output valid, output out_char, output last_of_run, input ready);
   modport sink (input valid, input out_char, input last_of_run, output ready);
endinterface

FILE: src/quoted_printable_encoder.sv
`timescale 1ns / 1ps

// channel   direction  payload                 handshake
// req_chan  in         command, in_byte        valid / ready
// rsp_chan  out        out_char, last_of_run   valid / ready
// csr_*     in         csr_index, csr_data     csr_write_enable, no wait
//
// One character leaves per cycle from the run buffer while rsp_chan is ready; a
// transaction makes as many characters as its run holds (1 for a literal, 3 for an
// escape, up to 9 with soft breaks; an end command on an empty line makes none).
// The next transaction is taken in the cycle the last character of the run leaves.
// Synchronous reset clears column and space flag, empties the run buffer, and loads the break
// columns with 72 and 75.
// A stalled rsp_chan holds the current character and blocks req_chan.

module quoted_printable_encoder
   import qpe_pkg::*;
(
   input logic clock,
   input logic reset,
   qpe_req_if.sink req_chan,
   qpe_rsp_if.source rsp_chan,
   input logic csr_write_enable,
   input csr_index_type csr_index,
   input logic [BREAK_COLUMN_WIDTH-1:0] csr_data
);

   logic [BREAK_COLUMN_WIDTH-1:0] escape_break_ff, escape_break_in;
   logic [BREAK_COLUMN_WIDTH-1:0] literal_break_ff, literal_break_in;
   line_state_type state_ff, state_in;
   line_state_type state_next;
   run_type run;
   logic accept;
   logic load_ready;

   assign req_chan.ready = load_ready;
   assign accept = req_chan.valid && load_ready;

   qpe_encode u_encode (
      .command (req_chan.command),
      .in_byte (req_chan.in_byte),
      .state (state_ff),
      .escape_break_column (escape_break_ff),
      .literal_break_column (literal_break_ff),
      .run (run),
      .state_next (state_next)
   );

   qpe_emit u_emit (
      .clock (clock),
      .reset (reset),
      .load (accept),
      .run (run),
      .load_ready (load_ready),
      .rsp_chan (rsp_chan)
   );

   always_comb begin
      state_in = accept ? state_next : state_ff;
      escape_break_in = escape_break_ff;
      literal_break_in = literal_break_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_ESCAPE_BREAK_COLUMN: escape_break_in = csr_data;
            CSR_LITERAL_BREAK_COLUMN: literal_break_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
         escape_break_ff <= ESCAPE_BREAK_RESET;
         literal_break_ff <= LITERAL_BREAK_RESET;
      end else begin
         state_ff <= state_in;
         escape_break_ff <= escape_break_in;
         literal_break_ff <= literal_break_in;
      end
   end

endmodule

FILE: src/qpe_encode.sv
`timescale 1ns / 1ps

module qpe_encode
   import qpe_pkg::*;
(
   input logic command,
   input logic [7:0] in_byte,
   input line_state_type state,
   input logic [BREAK_COLUMN_WIDTH-1:0] escape_break_column,
   input logic [BREAK_COLUMN_WIDTH-1:0] literal_break_column,
   output run_type run,
   output line_state_type state_next
);

   logic is_escape;
   logic pre_break;
   logic post_break;
   logic [RUN_COUNT_WIDTH-1:0] base;
   logic [COLUMN_WIDTH-1:0] column_base;

   always_comb begin
      is_escape = (in_byte == CHAR_EQUALS) || (in_byte < PRINTABLE_LOW)
         || (in_byte > PRINTABLE_HIGH)
         || ((in_byte == CHAR_DASH) && (state.column == '0))
         || (((in_byte == CHAR_CR) || (in_byte == CHAR_LF)) && state.after_space);
      post_break = (in_byte == CHAR_LF) && state.after_space;
      if (is_escape) begin
         pre_break = state.column > {1'b0, escape_break_column};
      end else begin
         pre_break = state.column > {1'b0, literal_break_column};
      end
      base = pre_break ? RUN_COUNT_WIDTH'(3) : '0;
      column_base = pre_break ? '0 : state.column;

      run.chars = '0;
      run.count = '0;
      state_next = state;

      if (command == CMD_END) begin
         run.chars[0] = CHAR_EQUALS;
         run.chars[1] = CHAR_CR;
         run.chars[2] = CHAR_LF;
         run.count = (state.column != '0) ? RUN_COUNT_WIDTH'(3) : '0;
         state_next.column = '0;
         state_next.after_space = 1'b0;
      end else begin
         if (pre_break) begin
            run.chars[0] = CHAR_EQUALS;
            run.chars[1] = CHAR_CR;
            run.chars[2] = CHAR_LF;
         end
         if (is_escape) begin
            run.chars[base] = CHAR_EQUALS;
            run.chars[base + RUN_COUNT_WIDTH'(1)] = hex_digit(in_byte[7:4]);
            run.chars[base + RUN_COUNT_WIDTH'(2)] = hex_digit(in_byte[3:0]);
            state_next.after_space = 1'b0;
            if (post_break) begin
               run.chars[base + RUN_COUNT_WIDTH'(3)] = CHAR_EQUALS;
               run.chars[base + RUN_COUNT_WIDTH'(4)] = CHAR_CR;
               run.chars[base + RUN_COUNT_WIDTH'(5)] = CHAR_LF;
               run.count = base + RUN_COUNT_WIDTH'(6);
               state_next.column = '0;
            end else begin
               run.count = base + RUN_COUNT_WIDTH'(3);
               state_next.column = column_base + ESCAPE_COLUMNS;
            end
         end else begin
            run.chars[base] = in_byte;
            run.count = base + RUN_COUNT_WIDTH'(1);
            state_next.column = column_base + COLUMN_WIDTH'(1);
            state_next.after_space = (in_byte == CHAR_SPACE) || (in_byte == CHAR_TAB);
         end
      end
   end

endmodule

FILE: src/qpe_emit.sv
`timescale 1ns / 1ps

module qpe_emit
   import qpe_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic load,
   input run_type run,
   output logic load_ready,
   qpe_rsp_if.source rsp_chan
);

   char_type [RUN_MAX-1:0] chars_ff, chars_in;
   logic [RUN_COUNT_WIDTH-1:0] remaining_ff, remaining_in;
   logic take;

   assign take = rsp_chan.valid && rsp_chan.ready;
   assign rsp_chan.valid = remaining_ff != '0;
   assign rsp_chan.out_char = chars_ff[0];
   assign rsp_chan.last_of_run = remaining_ff == RUN_COUNT_WIDTH'(1);
   assign load_ready = (remaining_ff == '0)
      || ((remaining_ff == RUN_COUNT_WIDTH'(1)) && rsp_chan.ready);

   always_comb begin
      chars_in = chars_ff;
      remaining_in = remaining_ff;
      if (load) begin
         chars_in = run.chars;
         remaining_in = run.count;
      end else if (take) begin
         chars_in = {8'h00, chars_ff[RUN_MAX-1:1]};
         remaining_in = remaining_ff - RUN_COUNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      chars_ff <= chars_in;
      if (reset) begin
         remaining_ff <= '0;
      end else begin
         remaining_ff <= remaining_in;
      end
   end

endmodule
